[src/tdsm_pkg.sv]
// tdsm_pkg: shared types, codes and helpers of the table-driven state machine
// used by tdsm_ctrl, tdsm_datapath and table_driven_state_machine
package tdsm_pkg;

  // default sizes of the tables
  localparam int NUM_STATES_DEF = 16;
  localparam int NUM_RULES_DEF  = 32;

  // input and output vector limits
  localparam int NUM_INPUTS  = 8;
  localparam int NUM_OUTPUTS = 8;

  // field widths of the item formats
  localparam int STATE_W = 4;
  localparam int INDEX_W = 5;
  localparam int VEC_W   = 8;
  localparam int MODE_W  = 2;

  // stream and configuration port widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  // item kinds carried on s_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_STEP        = 2'd0,
    MODE_WRITE_RULE  = 2'd1,
    MODE_WRITE_OUT   = 2'd2,
    MODE_RESTART     = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RULES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_STATE = 3'd4;

  // configuration reset values
  localparam logic [STATE_W-1:0] INIT_STATE_RST  = 4'd0;
  localparam logic [STATE_W-1:0] ERROR_STATE_RST = 4'd15;

  // one entry of the rule memory (valid bit kept apart)
  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [VEC_W-1:0]   care_mask;
    logic [VEC_W-1:0]   match_bits;
  } rule_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT_RD,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic out_rd;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_step;
    logic scan_done;
    logic out_free;
  } dp_status_t;

  // low bits set for min(count, limit, VEC_W) positions
  function automatic logic [VEC_W-1:0] low_mask(input logic [3:0] count, input int limit);
    logic [VEC_W-1:0] m;
    m = '0;
    for (int b = 0; b < VEC_W; b++) begin
      m[b] = (b < int'(count)) && (b < limit);
    end
    return m;
  endfunction

endpackage

[src/table_driven_state_machine.sv]
// table_driven_state_machine: programmable Moore machine driven by a rule table
// built from tdsm_ctrl and tdsm_datapath; depends on tdsm_pkg
//
// Channels: items arrive on s_tvalid/s_tready with the item kind on s_tuser
// (step, write rule, write state outputs, restart) and the other fields on
// s_tdata. Every item gives exactly one result on m_tvalid/m_tready: the state
// after the item, its output vector masked to the outputs in use, a no-match
// flag and the winning rule index. Registers are written on cfg_valid/cfg_ready
// (always ready); the user must write them only while the block is idle; the
// block itself does not enforce this. Flow: one item at a time. A step scans the
// rules in order up to the winning rule, or with no match all rules in use
// (num_rules_used capped at NUM_RULES), or none with none in use; the rule
// memory gives one entry per cycle and the scan is pipelined behind its
// registered read. Write and restart items skip the scan. The result stands
// in an output register, so a new item is taken while it waits.
// Reset: registers go to their reset values, all rule valid bits and state
// output valid bits are cleared at once, and the machine sits in state 0.
// A stalled receiver holds the result; after the next item has been worked,
// the block waits until the output register is free.
module table_driven_state_machine #(
  parameter int NUM_STATES = tdsm_pkg::NUM_STATES_DEF,
  parameter int NUM_RULES  = tdsm_pkg::NUM_RULES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // entry_index[4:0], from_state[8:5], to_state[12:9], care_mask[20:13],
  // match_bits[28:21], input_bits[36:29], output_bits[44:37]
  input  logic [tdsm_pkg::S_TDATA_W-1:0]   s_tdata,
  // mode[1:0]
  input  logic [tdsm_pkg::MODE_W-1:0]      s_tuser,
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // new_state[3:0], state_outputs[11:4], no_rule_matched[12], matched_rule[17:13]
  output logic [tdsm_pkg::M_TDATA_W-1:0]   m_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tdsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdsm_pkg::CFG_DAT_W-1:0]   cfg_data
);

  tdsm_pkg::ctrl_cmd_t  cmd;
  tdsm_pkg::dp_status_t status;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // sequencing
  tdsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, state and result
  tdsm_datapath #(
    .NUM_STATES (NUM_STATES),
    .NUM_RULES  (NUM_RULES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (s_tuser),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[src/tdsm_ctrl.sv]
// tdsm_ctrl: sequencing of one item through scan, output lookup and result load
// depends on tdsm_pkg
module tdsm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tdsm_pkg::dp_status_t   status,
  output tdsm_pkg::ctrl_cmd_t    cmd
);

  tdsm_pkg::ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_is_step ? tdsm_pkg::ST_SCAN : tdsm_pkg::ST_OUT_RD;
        end
      end
      tdsm_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = tdsm_pkg::ST_OUT_RD;
      end
      tdsm_pkg::ST_OUT_RD: begin
        state_next = tdsm_pkg::ST_FINISH;
      end
      tdsm_pkg::ST_FINISH: begin
        if (status.out_free) state_next = tdsm_pkg::ST_IDLE;
      end
      default: begin
        state_next = tdsm_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      tdsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tdsm_pkg::ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.commit = status.scan_done;
      end
      tdsm_pkg::ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
      end
      tdsm_pkg::ST_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/tdsm_datapath.sv]
// tdsm_datapath: configuration registers, rule memory, state output table,
// current state, scan pipeline and result register; depends on tdsm_pkg
module tdsm_datapath #(
  parameter int NUM_STATES = tdsm_pkg::NUM_STATES_DEF,
  parameter int NUM_RULES  = tdsm_pkg::NUM_RULES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [tdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdsm_pkg::CFG_DAT_W-1:0]    cfg_data,
  // input item
  input  logic [tdsm_pkg::MODE_W-1:0]       in_mode,
  input  logic [tdsm_pkg::S_TDATA_W-1:0]    in_data,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdsm_pkg::M_TDATA_W-1:0]    out_data,
  // control
  input  tdsm_pkg::ctrl_cmd_t               cmd,
  output tdsm_pkg::dp_status_t              status
);

  localparam int RIDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int CNT_W  = $clog2(NUM_RULES + 1);
  localparam int SIDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  // input fields
  logic [tdsm_pkg::INDEX_W-1:0] entry_index;
  logic [tdsm_pkg::STATE_W-1:0] from_state;
  logic [tdsm_pkg::STATE_W-1:0] to_state;
  logic [tdsm_pkg::VEC_W-1:0]   care_mask;
  logic [tdsm_pkg::VEC_W-1:0]   match_bits;
  logic [tdsm_pkg::VEC_W-1:0]   input_bits;
  logic [tdsm_pkg::VEC_W-1:0]   output_bits;

  assign entry_index = in_data[4:0];
  assign from_state  = in_data[8:5];
  assign to_state    = in_data[12:9];
  assign care_mask   = in_data[20:13];
  assign match_bits  = in_data[28:21];
  assign input_bits  = in_data[36:29];
  assign output_bits = in_data[44:37];

  // configuration registers
  logic [5:0]                   num_rules_used;
  logic [3:0]                   num_inputs_used;
  logic [3:0]                   num_outputs_used;
  logic [tdsm_pkg::STATE_W-1:0] initial_state;
  logic [tdsm_pkg::STATE_W-1:0] error_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rules_used   <= '0;
      num_inputs_used  <= '0;
      num_outputs_used <= '0;
      initial_state    <= tdsm_pkg::INIT_STATE_RST;
      error_state      <= tdsm_pkg::ERROR_STATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tdsm_pkg::REG_NUM_RULES:   num_rules_used   <= cfg_data;
        tdsm_pkg::REG_NUM_INPUTS:  num_inputs_used  <= cfg_data[3:0];
        tdsm_pkg::REG_NUM_OUTPUTS: num_outputs_used <= cfg_data[3:0];
        tdsm_pkg::REG_INIT_STATE:  initial_state    <= cfg_data[3:0];
        tdsm_pkg::REG_ERROR_STATE: error_state      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // decode of the accepted item
  logic wr_rule, wr_out, do_restart;
  logic [RIDX_W-1:0] rule_widx;
  logic [SIDX_W-1:0] out_widx;

  assign wr_rule    = cmd.load && (in_mode == tdsm_pkg::MODE_WRITE_RULE) &&
                      (int'(entry_index) < NUM_RULES);
  assign wr_out     = cmd.load && (in_mode == tdsm_pkg::MODE_WRITE_OUT) &&
                      (int'(entry_index) < NUM_STATES);
  assign do_restart = cmd.load && (in_mode == tdsm_pkg::MODE_RESTART);
  assign rule_widx  = RIDX_W'(entry_index);
  assign out_widx   = SIDX_W'(entry_index);

  // rule memory and its valid bits
  tdsm_pkg::rule_t   rule_mem [NUM_RULES];
  logic [NUM_RULES-1:0] rule_vld;
  tdsm_pkg::rule_t   rule_rd;
  logic              rule_rd_vld;

  // scan pipeline
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic [RIDX_W-1:0] pidx;
  logic [RIDX_W-1:0] raddr;
  logic              more_rules;
  logic              issue;

  assign raddr      = cnt[RIDX_W-1:0];
  assign more_rules = (cnt < num_rules_used) && (int'(cnt) < NUM_RULES);
  assign issue      = cmd.scan && more_rules;

  always_ff @(posedge clk) begin
    if (wr_rule) begin
      rule_mem[rule_widx] <= '{from_state: from_state, to_state: to_state,
                               care_mask: care_mask, match_bits: match_bits};
    end
    if (issue) begin
      rule_rd <= rule_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_vld <= '0;
    end else if (wr_rule) begin
      rule_vld[rule_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      pend        <= 1'b0;
      pidx        <= '0;
      rule_rd_vld <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan) begin
      pend <= issue;
      if (issue) begin
        cnt         <= cnt + 1'b1;
        pidx        <= raddr;
        rule_rd_vld <= rule_vld[raddr];
      end
    end
  end

  // current state and match test of the rule under evaluation
  logic [tdsm_pkg::STATE_W-1:0] cur_state;
  logic [tdsm_pkg::VEC_W-1:0]   inp_q;
  logic [tdsm_pkg::VEC_W-1:0]   imask;
  logic                         hit;

  assign imask = tdsm_pkg::low_mask(num_inputs_used, tdsm_pkg::NUM_INPUTS);
  assign hit   = pend && rule_rd_vld && (rule_rd.from_state == cur_state) &&
                 (((inp_q ^ rule_rd.match_bits) & rule_rd.care_mask & imask) == '0);

  logic                         nomatch_q;
  logic [tdsm_pkg::INDEX_W-1:0] winner_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inp_q     <= input_bits;
      nomatch_q <= 1'b0;
      winner_q  <= '0;
    end else if (cmd.commit) begin
      nomatch_q <= !hit;
      winner_q  <= hit ? tdsm_pkg::INDEX_W'(pidx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= tdsm_pkg::INIT_STATE_RST;
    end else if (do_restart) begin
      cur_state <= initial_state;
    end else if (cmd.commit) begin
      cur_state <= hit ? rule_rd.to_state : error_state;
    end
  end

  // state output table with valid bits, registered read at the current state
  logic [tdsm_pkg::VEC_W-1:0] out_mem [NUM_STATES];
  logic [NUM_STATES-1:0]      out_vld;
  logic [tdsm_pkg::VEC_W-1:0] out_rd;
  logic                       out_rd_set;
  logic [SIDX_W-1:0]          out_raddr;
  logic                       cur_in_range;

  assign out_raddr    = SIDX_W'(cur_state);
  assign cur_in_range = int'(cur_state) < NUM_STATES;

  always_ff @(posedge clk) begin
    if (wr_out) begin
      out_mem[out_widx] <= output_bits;
    end
    if (cmd.out_rd) begin
      out_rd <= out_mem[out_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld    <= '0;
      out_rd_set <= 1'b0;
    end else begin
      if (wr_out) out_vld[out_widx] <= 1'b1;
      if (cmd.out_rd) out_rd_set <= cur_in_range && out_vld[out_raddr];
    end
  end

  // result register
  logic [tdsm_pkg::VEC_W-1:0] outs_masked;

  assign outs_masked = (out_rd_set ? out_rd : '0) &
                       tdsm_pkg::low_mask(num_outputs_used, tdsm_pkg::NUM_OUTPUTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {6'b0, winner_q, nomatch_q, outs_masked, cur_state};
    end
  end

  // status back to the controller
  assign status.in_is_step = (in_mode == tdsm_pkg::MODE_STEP);
  assign status.scan_done  = hit || (!pend && !more_rules);
  assign status.out_free   = !out_valid || out_ready;

endmodule

[tb/tb.sv]
// tb: self-checking testbench for the table-driven state machine
// scoreboard class predicts every result; tasks drive the item and register channels
// depends on tdsm_pkg and table_driven_state_machine
`timescale 1ns / 100ps

module tb;

  localparam int VEC_W     = tdsm_pkg::VEC_W;
  localparam int STATE_W   = tdsm_pkg::STATE_W;
  localparam int INDEX_W   = tdsm_pkg::INDEX_W;
  localparam int MODE_W    = tdsm_pkg::MODE_W;
  localparam int S_TDATA_W = tdsm_pkg::S_TDATA_W;
  localparam int M_TDATA_W = tdsm_pkg::M_TDATA_W;
  localparam int CFG_IDX_W = tdsm_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = tdsm_pkg::CFG_DAT_W;

  localparam int N_STATES        = tdsm_pkg::NUM_STATES_DEF;
  localparam int N_RULES         = tdsm_pkg::NUM_RULES_DEF;
  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 250;

  // s_tdata layout, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [VEC_W-1:0]   output_bits;
    logic [VEC_W-1:0]   input_bits;
    logic [VEC_W-1:0]   match_bits;
    logic [VEC_W-1:0]   care_mask;
    logic [STATE_W-1:0] to_state;
    logic [STATE_W-1:0] from_state;
    logic [INDEX_W-1:0] entry_index;
  } item_fields_t;

  // m_tdata layout
  typedef struct packed {
    logic [5:0]         pad;
    logic [INDEX_W-1:0] matched_rule;
    logic               no_rule_matched;
    logic [VEC_W-1:0]   state_outputs;
    logic [STATE_W-1:0] new_state;
  } result_fields_t;

  typedef struct {
    bit                 valid;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [VEC_W-1:0]   care_mask;
    logic [VEC_W-1:0]   match_bits;
  } rule_slot_t;

  // machine tracker and result checker
  class tdsm_scoreboard;
    logic [5:0]         rules_used;
    logic [3:0]         inputs_used;
    logic [3:0]         outputs_used;
    logic [STATE_W-1:0] init_state;
    logic [STATE_W-1:0] err_state;
    logic [STATE_W-1:0] cur_state;
    rule_slot_t         rules [N_RULES];
    logic [VEC_W-1:0]   state_outs [N_STATES];
    result_fields_t     expected_reports [$];
    int mismatches, checked, n_steps, n_nomatch, n_writes, n_restarts;

    function new();
      rules_used   = '0;
      inputs_used  = '0;
      outputs_used = '0;
      init_state   = tdsm_pkg::INIT_STATE_RST;
      err_state    = tdsm_pkg::ERROR_STATE_RST;
      cur_state    = tdsm_pkg::INIT_STATE_RST;
      foreach (rules[i]) rules[i] = '{1'b0, '0, '0, '0, '0};
      foreach (state_outs[i]) state_outs[i] = '0;
    endfunction

    // low bits set for a count, saturating at the vector width
    function logic [VEC_W-1:0] lane_mask(logic [3:0] count);
      int n;
      n = (count > VEC_W) ? VEC_W : int'(count);
      return VEC_W'((1 << n) - 1);
    endfunction

    function int rules_in_use();
      return (rules_used > N_RULES) ? N_RULES : int'(rules_used);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        tdsm_pkg::REG_NUM_RULES:   rules_used   = val;
        tdsm_pkg::REG_NUM_INPUTS:  inputs_used  = val[3:0];
        tdsm_pkg::REG_NUM_OUTPUTS: outputs_used = val[3:0];
        tdsm_pkg::REG_INIT_STATE:  init_state   = val[STATE_W-1:0];
        tdsm_pkg::REG_ERROR_STATE: err_state    = val[STATE_W-1:0];
        default: ;
      endcase
    endfunction

    // input bits that satisfy some live rule of the current state
    function logic [VEC_W-1:0] steer_input(logic [VEC_W-1:0] fallback);
      int hits [$];
      int k;
      for (int i = 0; i < rules_in_use(); i++)
        if (rules[i].valid && rules[i].from_state == cur_state) hits.push_back(i);
      if (hits.size() == 0) return fallback;
      k = hits[$urandom_range(0, hits.size() - 1)];
      return (rules[k].match_bits & rules[k].care_mask) | (fallback & ~rules[k].care_mask);
    endfunction

    // advance the machine on an accepted item and queue its report
    function void predict_transition(tdsm_pkg::mode_t m, item_fields_t f);
      result_fields_t r;
      logic [VEC_W-1:0] imask;
      bit found;
      r = '0;
      case (m)
        tdsm_pkg::MODE_STEP: begin
          n_steps++;
          imask = lane_mask(inputs_used);
          found = 1'b0;
          for (int i = 0; i < rules_in_use() && !found; i++) begin
            if (rules[i].valid && rules[i].from_state == cur_state &&
                (((f.input_bits ^ rules[i].match_bits) & rules[i].care_mask & imask) == '0)) begin
              found          = 1'b1;
              cur_state      = rules[i].to_state;
              r.matched_rule = INDEX_W'(i);
            end
          end
          if (!found) begin
            cur_state         = err_state;
            r.no_rule_matched = 1'b1;
            n_nomatch++;
          end
        end
        tdsm_pkg::MODE_WRITE_RULE: begin
          n_writes++;
          rules[f.entry_index] = '{1'b1, f.from_state, f.to_state, f.care_mask, f.match_bits};
        end
        tdsm_pkg::MODE_WRITE_OUT: begin
          n_writes++;
          if (f.entry_index < N_STATES) state_outs[f.entry_index[STATE_W-1:0]] = f.output_bits;
        end
        default: begin
          n_restarts++;
          cur_state = init_state;
        end
      endcase
      r.new_state     = cur_state;
      r.state_outputs = state_outs[cur_state] & lane_mask(outputs_used);
      expected_reports.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(result_fields_t got);
      result_fields_t want;
      checked++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_reports.pop_front();
      if (got.new_state !== want.new_state)
        report_mismatch($sformatf("new_state %h, expected %h", got.new_state, want.new_state));
      if (got.state_outputs !== want.state_outputs)
        report_mismatch($sformatf("state_outputs %h, expected %h",
                                  got.state_outputs, want.state_outputs));
      if (got.no_rule_matched !== want.no_rule_matched)
        report_mismatch($sformatf("no_rule_matched %b, expected %b",
                                  got.no_rule_matched, want.no_rule_matched));
      if (got.matched_rule !== want.matched_rule)
        report_mismatch($sformatf("matched_rule %0d, expected %0d",
                                  got.matched_rule, want.matched_rule));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [MODE_W-1:0]    s_tuser   = tdsm_pkg::MODE_STEP;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = tdsm_pkg::REG_NUM_RULES;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  tdsm_scoreboard sb;
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;
  int n_settings   = 0;

  table_driven_state_machine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sample every transfer at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(result_fields_t'(m_tdata));
      if (s_tvalid && s_tready)
        sb.predict_transition(tdsm_pkg::mode_t'(s_tuser), item_fields_t'(s_tdata));
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result receiver with random stalls and requested long holds
  initial begin : result_sink
    int gap;
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (hold_request) begin
        gap          = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  function automatic item_fields_t pack_item(int idx, int from_s, int to_s, int care,
                                             int match, int inp, int outv);
    item_fields_t f;
    f             = '0;
    f.entry_index = INDEX_W'(idx);
    f.from_state  = STATE_W'(from_s);
    f.to_state    = STATE_W'(to_s);
    f.care_mask   = VEC_W'(care);
    f.match_bits  = VEC_W'(match);
    f.input_bits  = VEC_W'(inp);
    f.output_bits = VEC_W'(outv);
    return f;
  endfunction

  function automatic item_fields_t rand_fields();
    item_fields_t f;
    f     = item_fields_t'(S_TDATA_W'({$urandom(), $urandom()}));
    f.pad = '0;
    return f;
  endfunction

  // one item transfer; valid stays high when no gap follows
  task automatic send_item(input tdsm_pkg::mode_t m, input item_fields_t f);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= f;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // mostly steps steered toward live rules, plus table writes and restarts
  task automatic send_random_item();
    item_fields_t f;
    int pick;
    f    = rand_fields();
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      if ($urandom_range(0, 9) < 7) f.input_bits = sb.steer_input(f.input_bits);
      send_item(tdsm_pkg::MODE_STEP, f);
    end else if (pick < 82) begin
      if ($urandom_range(0, 3) != 0) f.care_mask &= VEC_W'($urandom());
      send_item(tdsm_pkg::MODE_WRITE_RULE, f);
    end else if (pick < 92) begin
      if ($urandom_range(0, 4) != 0) f.entry_index[INDEX_W-1] = 1'b0;
      send_item(tdsm_pkg::MODE_WRITE_OUT, f);
    end else begin
      send_item(tdsm_pkg::MODE_RESTART, f);
    end
  endtask

  // stop offering and wait for every pending report
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
  endtask

  // write all five registers, block idle
  task automatic configure(input int n_rules, input int n_in, input int n_out,
                           input int init_s, input int err_s);
    logic [CFG_IDX_W-1:0] idx [5];
    int val [5];
    idx = '{tdsm_pkg::REG_NUM_RULES, tdsm_pkg::REG_NUM_INPUTS, tdsm_pkg::REG_NUM_OUTPUTS,
            tdsm_pkg::REG_INIT_STATE, tdsm_pkg::REG_ERROR_STATE};
    val = '{n_rules, n_in, n_out, init_s, err_s};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= CFG_DAT_W'(val[k]);
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: no rules in use, so steps fall to the error state
    send_item(tdsm_pkg::MODE_STEP,       pack_item(0, 0, 0, 0, 0, 8'h00, 0));
    send_item(tdsm_pkg::MODE_RESTART,    pack_item(0, 0, 0, 0, 0, 0, 0));
    send_item(tdsm_pkg::MODE_WRITE_OUT,  pack_item(0, 0, 0, 0, 0, 0, 8'hA5));
    send_item(tdsm_pkg::MODE_WRITE_OUT,  pack_item(1, 0, 0, 0, 0, 0, 8'h5A));
    send_item(tdsm_pkg::MODE_WRITE_OUT,  pack_item(15, 0, 0, 0, 0, 0, 8'hFF));
    // output writes past the state count are dropped
    send_item(tdsm_pkg::MODE_WRITE_OUT,  pack_item(16, 0, 0, 0, 0, 0, 8'h3C));
    send_item(tdsm_pkg::MODE_WRITE_OUT,  pack_item(31, 0, 0, 0, 0, 0, 8'hC3));
    send_item(tdsm_pkg::MODE_WRITE_RULE, pack_item(0, 0, 1, 8'hFF, 8'hFF, 0, 0));
    send_item(tdsm_pkg::MODE_WRITE_RULE, pack_item(1, 0, 2, 8'h81, 8'h80, 0, 0));
    send_item(tdsm_pkg::MODE_WRITE_RULE, pack_item(5, 1, 0, 8'h00, 8'h00, 0, 0));
    send_item(tdsm_pkg::MODE_WRITE_RULE, pack_item(31, 2, 7, 8'h0F, 8'h05, 0, 0));
    send_item(tdsm_pkg::MODE_STEP,       pack_item(0, 0, 0, 0, 0, 8'hFF, 0));
    send_item(tdsm_pkg::MODE_RESTART,    pack_item(0, 0, 0, 0, 0, 0, 0));
    drain();

    // saturated counts, zero inputs: first valid rule of the state wins
    configure(63, 0, 15, 0, 9);
    send_item(tdsm_pkg::MODE_STEP, pack_item(0, 0, 0, 0, 0, 8'h00, 0));
    send_item(tdsm_pkg::MODE_STEP, pack_item(0, 0, 0, 0, 0, 8'h00, 0));
    drain();

    // full inputs: care masks decide, unmatched state goes to error
    configure(32, 8, 4, 15, 0);
    send_item(tdsm_pkg::MODE_STEP,    pack_item(0, 0, 0, 0, 0, 8'hFF, 0));
    send_item(tdsm_pkg::MODE_STEP,    pack_item(0, 0, 0, 0, 0, 8'h00, 0));
    send_item(tdsm_pkg::MODE_STEP,    pack_item(0, 0, 0, 0, 0, 8'h80, 0));
    send_item(tdsm_pkg::MODE_STEP,    pack_item(0, 0, 0, 0, 0, 8'h15, 0));
    send_item(tdsm_pkg::MODE_STEP,    pack_item(0, 0, 0, 0, 0, 8'h00, 0));
    send_item(tdsm_pkg::MODE_RESTART, pack_item(0, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases over several register settings
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: configure(32, 8, 8, 0, 15);
        1: configure(63, 15, 15, 15, 0);
        2: configure(6, 3, 5, 7, 7);
        3: configure(1, 1, 1, 3, 12);
        default: configure($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      idle_on = (p != 0);
      if (p == 1 || p == 4) hold_request = 1'b1;
      send_item(tdsm_pkg::MODE_RESTART, rand_fields());
      repeat (ITEMS_PER_PHASE) send_random_item();
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d steps (%0d without a matching rule), %0d table writes, %0d restarts",
             sb.n_steps, sb.n_nomatch, sb.n_writes, sb.n_restarts);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             n_settings + 1, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[table_driven_state_machine.f]
src/tdsm_pkg.sv
src/tdsm_ctrl.sv
src/tdsm_datapath.sv
src/table_driven_state_machine.sv
tb/tb.sv
